[design/dtl_pkg.sv]
package dtl_pkg;

    // Field widths
    localparam int POS_W  = 32;
    localparam int STEP_W = 25;
    localparam int BTN_W  = 5;
    localparam int SEL_W  = 16;
    localparam int VAR_W  = 8;
    localparam int VCNT_W = 9;

    // Loop end after reset
    localparam logic [POS_W-1:0] POS_ONES = '1;

    // Button bit positions
    localparam int BTN_B0 = 0;  // monitor / shift
    localparam int BTN_B1 = 1;  // loop in / restart
    localparam int BTN_B2 = 2;  // loop out / cue jump
    localparam int BTN_B3 = 3;  // reloop / cue set
    localparam int BTN_B4 = 4;  // play / reverse

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_CONTROL = 2'd1,
        OP_LOCK    = 2'd2,
        OP_UNLOCK  = 2'd3
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch input transaction
        logic apply;       // control, lock or unlock
        logic mul;         // register step * block size
        logic add;         // position update with clamp/wrap
        logic fold_start;  // launch loop remainder
        logic fix;         // position = loop start + remainder
        logic load_out;    // snapshot state into output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_adv;
        logic ready;
        logic fold_need;
        logic div_busy;
    } t_dp_sts;

endpackage

[design/dtl_rem.sv]
module dtl_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dtl_pkg::POS_W-1:0]  i_dividend,
    input  logic [dtl_pkg::POS_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [dtl_pkg::POS_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(dtl_pkg::POS_W);

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [dtl_pkg::POS_W-1:0] r_dvd;
    logic [dtl_pkg::POS_W-1:0] r_dvs;
    logic [dtl_pkg::POS_W-1:0] r_rem;
    logic [dtl_pkg::POS_W:0]   w_rem_sh;
    logic [dtl_pkg::POS_W:0]   w_rem_sub;

    // Restoring remainder, one dividend bit per cycle
    assign w_rem_sh  = {r_rem, r_dvd[dtl_pkg::POS_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(dtl_pkg::POS_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[dtl_pkg::POS_W-2:0], 1'b0};
            if (w_rem_sh >= {1'b0, r_dvs}) begin
                r_rem <= w_rem_sub[dtl_pkg::POS_W-1:0];
            end else begin
                r_rem <= w_rem_sh[dtl_pkg::POS_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

    // Finished remainder is below the divisor
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_rem < r_dvs))
        else $error("remainder not below loop length");

endmodule

[design/dtl_dp.sv]
module dtl_dp #(
    parameter int BLOCK_SAMPLES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dtl_pkg::t_dp_cmd            i_cmd,
    output dtl_pkg::t_dp_sts            o_sts,
    input  logic                        i_cfg_we,
    input  logic [dtl_pkg::VCNT_W-1:0]  i_cfg_data,
    input  logic [1:0]                  i_operation,
    input  logic signed [dtl_pkg::STEP_W-1:0] i_step,
    input  logic [dtl_pkg::BTN_W-1:0]   i_pressed,
    input  logic [dtl_pkg::BTN_W-1:0]   i_released,
    input  logic [dtl_pkg::BTN_W-1:0]   i_held,
    input  logic signed [dtl_pkg::SEL_W-1:0] i_selector,
    output logic [dtl_pkg::POS_W-1:0]   o_position,
    output logic [dtl_pkg::POS_W-1:0]   o_cue_position,
    output logic [dtl_pkg::POS_W-1:0]   o_loop_begin,
    output logic [dtl_pkg::POS_W-1:0]   o_loop_finish,
    output logic                        o_ready_res,
    output logic                        o_playing,
    output logic                        o_looping,
    output logic                        o_reversed,
    output logic                        o_monitoring,
    output logic [dtl_pkg::VAR_W-1:0]   o_variant
);

    localparam int BS_W   = $clog2(BLOCK_SAMPLES + 1);
    localparam int PROD_W = dtl_pkg::STEP_W + BS_W + 1;
    localparam int ADD_W  = (PROD_W >= dtl_pkg::POS_W + 1) ? PROD_W + 1 : dtl_pkg::POS_W + 2;
    localparam logic [BS_W-1:0] BS_VAL = BS_W'(BLOCK_SAMPLES);

    // Captured transaction
    dtl_pkg::t_op                       r_op;
    logic signed [dtl_pkg::STEP_W-1:0]  r_step;
    logic [dtl_pkg::BTN_W-1:0]          r_pressed;
    logic [dtl_pkg::BTN_W-1:0]          r_released;
    logic [dtl_pkg::BTN_W-1:0]          r_held;
    logic                               r_sel_neg;
    logic                               r_sel_nz;

    // Deck state
    logic [dtl_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [dtl_pkg::POS_W-1:0]  r_cue, n_cue;
    logic [dtl_pkg::POS_W-1:0]  r_start, n_start;
    logic [dtl_pkg::POS_W-1:0]  r_end, n_end;
    logic                       r_ready, n_ready;
    logic                       r_playing, n_playing;
    logic                       r_looping, n_looping;
    logic                       r_reversed, n_reversed;
    logic                       r_monitoring, n_monitoring;
    logic                       r_shifted, n_shifted;
    logic [dtl_pkg::VAR_W-1:0]  r_variant, n_variant;
    logic [dtl_pkg::VCNT_W-1:0] r_vcount;

    logic signed [PROD_W-1:0]   r_delta;
    logic signed [PROD_W-1:0]   w_prod;
    logic [ADD_W-1:0]           w_sum;
    logic [dtl_pkg::POS_W-1:0]  w_loopin_end;
    logic                       w_var_up_ok;
    logic                       w_div_busy;
    logic [dtl_pkg::POS_W-1:0]  w_rem;

    // Output register
    logic [dtl_pkg::POS_W-1:0]  r_out_pos;
    logic [dtl_pkg::POS_W-1:0]  r_out_cue;
    logic [dtl_pkg::POS_W-1:0]  r_out_start;
    logic [dtl_pkg::POS_W-1:0]  r_out_end;
    logic                       r_out_ready;
    logic                       r_out_playing;
    logic                       r_out_looping;
    logic                       r_out_reversed;
    logic                       r_out_monitoring;
    logic [dtl_pkg::VAR_W-1:0]  r_out_variant;

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= dtl_pkg::t_op'(i_operation);
            r_step     <= i_step;
            r_pressed  <= i_pressed;
            r_released <= i_released;
            r_held     <= i_held;
            r_sel_neg  <= i_selector[dtl_pkg::SEL_W-1];
            r_sel_nz   <= (i_selector != '0);
        end
    end

    // Variant count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= dtl_pkg::VCNT_W'(1);
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    // Step times block size
    assign w_prod = r_step * $signed({1'b0, BS_VAL});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_delta <= w_prod;
        end
    end

    // Position plus delta; a negative sum means underflow and clamps to zero
    assign w_sum = {{(ADD_W - dtl_pkg::POS_W){1'b0}}, r_pos}
                 + {{(ADD_W - PROD_W){r_delta[PROD_W-1]}}, r_delta};

    assign w_loopin_end = r_pos + (r_end - r_start);
    assign w_var_up_ok  = (r_variant != '1) &&
                          (({1'b0, r_variant} + dtl_pkg::VCNT_W'(1)) < r_vcount);

    // Loop remainder unit
    dtl_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.fold_start),
        .i_dividend (r_pos - r_end),
        .i_divisor  (r_end - r_start),
        .o_busy     (w_div_busy),
        .o_rem      (w_rem)
    );

    // Next state
    always_comb begin
        n_pos        = r_pos;
        n_cue        = r_cue;
        n_start      = r_start;
        n_end        = r_end;
        n_ready      = r_ready;
        n_playing    = r_playing;
        n_looping    = r_looping;
        n_reversed   = r_reversed;
        n_monitoring = r_monitoring;
        n_shifted    = r_shifted;
        n_variant    = r_variant;

        if (i_cmd.apply) begin
            case (r_op)
                dtl_pkg::OP_CONTROL: begin
                    if (r_held[dtl_pkg::BTN_B0]) begin
                        // shift mode
                        if (r_sel_nz && r_ready) begin
                            if (r_sel_neg) begin
                                if (r_variant != '0) begin
                                    n_variant = r_variant - 1'b1;
                                end
                            end else if (w_var_up_ok) begin
                                n_variant = r_variant + 1'b1;
                            end
                        end
                        if (r_pressed[dtl_pkg::BTN_B1]) begin
                            n_pos = '0;
                        end
                        if (r_pressed[dtl_pkg::BTN_B2]) begin
                            n_pos = r_cue;
                        end
                        if (r_pressed[dtl_pkg::BTN_B3]) begin
                            n_cue = n_pos;
                        end
                        if (r_pressed[dtl_pkg::BTN_B4]) begin
                            n_reversed = ~r_reversed;
                        end
                        if (r_pressed[dtl_pkg::BTN_W-1:1] != '0) begin
                            n_shifted = 1'b1;
                        end
                    end else begin
                        // normal mode; loop in past the end moves the whole loop
                        if (r_pressed[dtl_pkg::BTN_B1]) begin
                            n_start = r_pos;
                            if (r_pos > r_end) begin
                                n_end = w_loopin_end;
                            end
                        end
                        if (r_pressed[dtl_pkg::BTN_B2] && (r_pos > n_start)) begin
                            n_end     = r_pos;
                            n_looping = 1'b1;
                        end
                        if (r_pressed[dtl_pkg::BTN_B3] && (n_end > n_start)) begin
                            n_looping = ~n_looping;
                        end
                        if (r_pressed[dtl_pkg::BTN_B4]) begin
                            n_playing = ~r_playing;
                        end
                        if (r_released[dtl_pkg::BTN_B0] && !r_shifted) begin
                            n_monitoring = ~r_monitoring;
                        end
                        n_shifted = 1'b0;
                    end
                end
                dtl_pkg::OP_LOCK: begin
                    n_ready = 1'b0;
                end
                dtl_pkg::OP_UNLOCK: begin
                    n_ready = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.add) begin
            n_pos = w_sum[ADD_W-1] ? '0 : w_sum[dtl_pkg::POS_W-1:0];
        end

        if (i_cmd.fix) begin
            n_pos = r_start + w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_cue        <= '0;
            r_start      <= '0;
            r_end        <= dtl_pkg::POS_ONES;
            r_ready      <= 1'b0;
            r_playing    <= 1'b0;
            r_looping    <= 1'b0;
            r_reversed   <= 1'b0;
            r_monitoring <= 1'b0;
            r_shifted    <= 1'b0;
            r_variant    <= '0;
        end else begin
            r_pos        <= n_pos;
            r_cue        <= n_cue;
            r_start      <= n_start;
            r_end        <= n_end;
            r_ready      <= n_ready;
            r_playing    <= n_playing;
            r_looping    <= n_looping;
            r_reversed   <= n_reversed;
            r_monitoring <= n_monitoring;
            r_shifted    <= n_shifted;
            r_variant    <= n_variant;
        end
    end

    // Result snapshot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pos        <= r_pos;
            r_out_cue        <= r_cue;
            r_out_start      <= r_start;
            r_out_end        <= r_end;
            r_out_ready      <= r_ready;
            r_out_playing    <= r_playing;
            r_out_looping    <= r_looping;
            r_out_reversed   <= r_reversed;
            r_out_monitoring <= r_monitoring;
            r_out_variant    <= r_variant;
        end
    end

    assign o_position     = r_out_pos;
    assign o_cue_position = r_out_cue;
    assign o_loop_begin   = r_out_start;
    assign o_loop_finish  = r_out_end;
    assign o_ready_res    = r_out_ready;
    assign o_playing      = r_out_playing;
    assign o_looping      = r_out_looping;
    assign o_reversed     = r_out_reversed;
    assign o_monitoring   = r_out_monitoring;
    assign o_variant      = r_out_variant;

    // Status
    assign o_sts.is_adv    = (r_op == dtl_pkg::OP_ADVANCE);
    assign o_sts.ready     = r_ready;
    assign o_sts.fold_need = r_looping && (r_end > r_start) && (r_pos >= r_end);
    assign o_sts.div_busy  = w_div_busy;

    // A folded position lands inside the loop
    a_fold_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.fix) |-> ((r_pos >= r_start) && (r_pos < r_end)))
        else $error("folded position outside loop");

endmodule

[design/dtl_ctrl.sv]
module dtl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output dtl_pkg::t_dp_cmd  o_cmd,
    input  dtl_pkg::t_dp_sts  i_sts
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_ADD  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_adv) begin
                    if (i_sts.ready) begin
                        o_cmd.mul = 1'b1;
                        n_state   = S_ADD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_sts.fold_need) begin
                    o_cmd.fold_start = 1'b1;
                    n_state          = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    a_fold_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fold_start |=> i_sts.div_busy)
        else $error("remainder unit did not start");

    a_fix_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> !i_sts.div_busy)
        else $error("fix while remainder unit busy");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

endmodule

[design/deck_transport_loop_controller_core.sv]
// Deck transport controller: keeps play position, cue point, loop points, mode
// flags and variant index, and answers every input transaction with one result
// transaction holding a snapshot of that state. Lock, unlock, control and an
// advance while not ready pass execute and output before the result valid rises;
// a ready advance passes execute, add, check and output, plus divide and fix
// on a fold back into an active loop, with a one-bit-per-cycle remainder unit. One
// transaction is in work at a time; the next is accepted as soon as the
// previous result is in the output register, even if it is not yet taken.
// The variant_count register is written through the cfg channel, always ready.
module deck_transport_loop_controller_core #(
    parameter int BLOCK_SAMPLES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dtl_pkg::VCNT_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_operation,
    input  logic signed [dtl_pkg::STEP_W-1:0] i_step,
    input  logic [dtl_pkg::BTN_W-1:0]         i_pressed,
    input  logic [dtl_pkg::BTN_W-1:0]         i_released,
    input  logic [dtl_pkg::BTN_W-1:0]         i_held,
    input  logic signed [dtl_pkg::SEL_W-1:0]  i_selector,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dtl_pkg::POS_W-1:0]         o_position,
    output logic [dtl_pkg::POS_W-1:0]         o_cue_position,
    output logic [dtl_pkg::POS_W-1:0]         o_loop_begin,
    output logic [dtl_pkg::POS_W-1:0]         o_loop_finish,
    output logic                              o_ready_res,
    output logic                              o_playing,
    output logic                              o_looping,
    output logic                              o_reversed,
    output logic                              o_monitoring,
    output logic [dtl_pkg::VAR_W-1:0]         o_variant
);

    dtl_pkg::t_dp_cmd w_cmd;
    dtl_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    dtl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    dtl_dp #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_step         (i_step),
        .i_pressed      (i_pressed),
        .i_released     (i_released),
        .i_held         (i_held),
        .i_selector     (i_selector),
        .o_position     (o_position),
        .o_cue_position (o_cue_position),
        .o_loop_begin   (o_loop_begin),
        .o_loop_finish  (o_loop_finish),
        .o_ready_res    (o_ready_res),
        .o_playing      (o_playing),
        .o_looping      (o_looping),
        .o_reversed     (o_reversed),
        .o_monitoring   (o_monitoring),
        .o_variant      (o_variant)
    );

endmodule
